// ===== hw/rtl/rational_arith_reduce_assert.svh =====
// Assertion macros for the rational arithmetic reduce block
`ifndef RATIONAL_ARITH_REDUCE_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_ASSERT_SVH

// plain property check on the block clock, quiet in reset
`define RAR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// a stalled item keeps its payload until taken
`define RAR_ASSERT_HOLD(lbl, vld, rdy, sig) \
   lbl: assert property (@(posedge clock) disable iff (reset) \
      (vld && !rdy) |=> (vld && $stable(sig))) else $error("stalled item changed");

`endif

// ===== hw/rtl/rar_pkg.sv =====
// Types and constants shared by the rational arithmetic reduce block
`default_nettype none
package rar_pkg;

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_SUB = 2'd1;
   localparam logic [1:0] FUNC_MUL = 2'd2;
   localparam logic [1:0] FUNC_RED = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_D,
      ST_SUM,
      ST_GCD,
      ST_DIV,
      ST_FIN
   } rar_state_type;

   typedef enum logic [1:0] {
      MSEL_A,
      MSEL_B,
      MSEL_D
   } rar_msel_type;

   typedef struct packed {
      logic         load_in;
      logic         mul_en;
      rar_msel_type mul_sel;
      logic         sum_en;
      logic         gcd_en;
      logic         div_start;
      logic         div_en;
      logic         out_load;
   } rar_cmd_type;

   typedef struct packed {
      logic zero_den;
      logic num_zero;
      logic gcd_done;
   } rar_stat_type;

endpackage
`default_nettype wire

// ===== hw/rtl/rational_arith_reduce.sv =====
// Top level of the exact rational arithmetic unit with gcd reduction
// Each item carries two fractions a_num/a_den and b_num/b_den and an operation
// (add, subtract, multiply, or reduce the first fraction alone). Cross products
// are formed at 64 bits on one shared 33x33 multiplier, the sum is taken, and
// the result is divided by the gcd of its numerator magnitude and denominator.
// The gcd is found with a binary (shift and subtract) loop, one step a cycle;
// two restoring dividers then run side by side. One item is worked on at a
// time. A zero denominator is caught in the first multiply state and a zero
// numerator right after the sum; both skip to the output. The finished item
// sits in an output register, so the next item is accepted while it waits.
// Status: 0 ok, 1 zero denominator, 2 reduced value does not fit a signed
// WIDTH-bit numerator and WIDTH-1 bit denominator; on status 1 and 2 both
// fields read zero, and a zero result is 0/1.
`default_nettype none
module rational_arith_reduce #(
   parameter int WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95], zero fill
   input  wire logic [127:0] req_tdata,
   // func[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // res_num[31:0], res_den[62:32], zero fill
   output logic [63:0]       rsp_tdata,
   // status[1:0]
   output logic [1:0]        rsp_tuser
);
   rar_pkg::rar_cmd_type  cmd;
   rar_pkg::rar_stat_type stat;
   logic signed [31:0]    res_num;
   logic [30:0]           res_den;

   rar_control u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rar_datapath #(.WIDTH(WIDTH)) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .in_func  (req_tuser),
      .in_a_num (req_tdata[31:0]),
      .in_a_den (req_tdata[62:32]),
      .in_b_num (req_tdata[94:63]),
      .in_b_den (req_tdata[125:95]),
      .stat     (stat),
      .res_num  (res_num),
      .res_den  (res_den),
      .status   (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, res_den, res_num};

endmodule
`default_nettype wire

// ===== hw/rtl/rar_datapath.sv =====
// Datapath: shared multiplier, sum, binary gcd and two restoring dividers
`default_nettype none
module rar_datapath #(
   parameter int WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire rar_pkg::rar_cmd_type cmd,
   input  wire logic [1:0]           in_func,
   input  wire logic signed [31:0]   in_a_num,
   input  wire logic [30:0]          in_a_den,
   input  wire logic signed [31:0]   in_b_num,
   input  wire logic [30:0]          in_b_den,
   output rar_pkg::rar_stat_type     stat,
   output logic signed [31:0]        res_num,
   output logic [30:0]               res_den,
   output logic [1:0]                status
);
   localparam logic [63:0] LIM = (64'd1 << (WIDTH - 1)) - 64'd1;

   logic [1:0]          func_ff;
   logic signed [31:0]  an_ff, bn_ff;
   logic [30:0]         ad_ff, bd_ff;
   logic signed [63:0]  t0_ff, t1_ff;
   logic [63:0]         den_ff, mag_ff, x_ff, y_ff, g_ff;
   logic [63:0]         rem_a_ff, rem_b_ff, qa_ff, qb_ff;
   logic [5:0]          k_ff;
   logic                neg_ff, zero_ff;
   logic signed [31:0]  res_num_ff;
   logic [30:0]         res_den_ff;
   logic [1:0]          status_ff;

   logic signed [32:0]  op_a, op_b;
   logic signed [65:0]  prod;
   logic signed [63:0]  sum;
   logic [63:0]         den_sel, mag;
   logic [63:0]         sh_a, sh_b;
   logic                ovf;
   logic [63:0]         qa_neg;

   always_comb begin
      unique case (cmd.mul_sel)
         rar_pkg::MSEL_A: begin
            op_a = {an_ff[31], an_ff};
            op_b = (func_ff == rar_pkg::FUNC_MUL) ? {bn_ff[31], bn_ff} : {2'b00, bd_ff};
         end
         rar_pkg::MSEL_B: begin
            op_a = {bn_ff[31], bn_ff};
            op_b = {2'b00, ad_ff};
         end
         default: begin
            op_a = {2'b00, ad_ff};
            op_b = {2'b00, bd_ff};
         end
      endcase
      prod = op_a * op_b;
   end

   always_comb begin
      case (func_ff)
         rar_pkg::FUNC_ADD: sum = t0_ff + t1_ff;
         rar_pkg::FUNC_SUB: sum = t0_ff - t1_ff;
         rar_pkg::FUNC_MUL: sum = t0_ff;
         default:           sum = {{32{an_ff[31]}}, an_ff};
      endcase
      den_sel = (func_ff == rar_pkg::FUNC_RED) ? {33'd0, ad_ff} : den_ff;
      mag     = sum[63] ? 64'(-sum) : 64'(sum);
   end

   assign sh_a = {rem_a_ff[62:0], qa_ff[63]};
   assign sh_b = {rem_b_ff[62:0], qb_ff[63]};

   assign ovf    = (qb_ff > LIM) || (qa_ff > (LIM + {63'd0, neg_ff}));
   assign qa_neg = 64'd0 - qa_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         func_ff <= in_func;
         an_ff   <= in_a_num;
         ad_ff   <= in_a_den;
         bn_ff   <= in_b_num;
         bd_ff   <= in_b_den;
      end
      if (cmd.mul_en) begin
         unique case (cmd.mul_sel)
            rar_pkg::MSEL_A: t0_ff  <= prod[63:0];
            rar_pkg::MSEL_B: t1_ff  <= prod[63:0];
            default:         den_ff <= 64'(prod[63:0]);
         endcase
      end
      if (cmd.sum_en) begin
         mag_ff  <= mag;
         den_ff  <= den_sel;
         neg_ff  <= sum[63];
         zero_ff <= (sum == 64'sd0);
         x_ff    <= mag;
         y_ff    <= den_sel;
         k_ff    <= '0;
      end
      // Stein's gcd, one step a cycle
      if (cmd.gcd_en && (x_ff != y_ff)) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_ff <= x_ff >> 1;
            y_ff <= y_ff >> 1;
            k_ff <= k_ff + 6'd1;
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_ff <= x_ff - y_ff;
         end else begin
            y_ff <= y_ff - x_ff;
         end
      end
      if (cmd.div_start) begin
         g_ff     <= x_ff << k_ff;
         rem_a_ff <= '0;
         rem_b_ff <= '0;
         qa_ff    <= mag_ff;
         qb_ff    <= den_ff;
      end
      if (cmd.div_en) begin
         if (sh_a >= g_ff) begin
            rem_a_ff <= sh_a - g_ff;
            qa_ff    <= {qa_ff[62:0], 1'b1};
         end else begin
            rem_a_ff <= sh_a;
            qa_ff    <= {qa_ff[62:0], 1'b0};
         end
         if (sh_b >= g_ff) begin
            rem_b_ff <= sh_b - g_ff;
            qb_ff    <= {qb_ff[62:0], 1'b1};
         end else begin
            rem_b_ff <= sh_b;
            qb_ff    <= {qb_ff[62:0], 1'b0};
         end
      end
      if (cmd.out_load) begin
         if (stat.zero_den) begin
            res_num_ff <= '0;
            res_den_ff <= '0;
            status_ff  <= rar_pkg::STATUS_ZERO_DEN;
         end else if (zero_ff) begin
            res_num_ff <= '0;
            res_den_ff <= 31'd1;
            status_ff  <= rar_pkg::STATUS_OK;
         end else if (ovf) begin
            res_num_ff <= '0;
            res_den_ff <= '0;
            status_ff  <= rar_pkg::STATUS_OVERFLOW;
         end else begin
            res_num_ff <= neg_ff ? qa_neg[31:0] : qa_ff[31:0];
            res_den_ff <= qb_ff[30:0];
            status_ff  <= rar_pkg::STATUS_OK;
         end
      end
   end

   assign stat.zero_den = (ad_ff == '0) || ((func_ff != rar_pkg::FUNC_RED) && (bd_ff == '0));
   assign stat.num_zero = zero_ff;
   assign stat.gcd_done = (x_ff == y_ff);

   assign res_num = res_num_ff;
   assign res_den = res_den_ff;
   assign status  = status_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rar_control.sv =====
// Controller: sequences one item through multiply, gcd, divide and output
`default_nettype none
module rar_control (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire rar_pkg::rar_stat_type stat,
   output rar_pkg::rar_cmd_type       cmd
);
   rar_pkg::rar_state_type state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rar_pkg::ST_IDLE:  if (req_tvalid) state_in = rar_pkg::ST_MUL_A;
         rar_pkg::ST_MUL_A: state_in = stat.zero_den ? rar_pkg::ST_FIN : rar_pkg::ST_MUL_B;
         rar_pkg::ST_MUL_B: state_in = rar_pkg::ST_MUL_D;
         rar_pkg::ST_MUL_D: state_in = rar_pkg::ST_SUM;
         rar_pkg::ST_SUM:   state_in = rar_pkg::ST_GCD;
         rar_pkg::ST_GCD: begin
            if (stat.num_zero) state_in = rar_pkg::ST_FIN;
            else if (stat.gcd_done) state_in = rar_pkg::ST_DIV;
         end
         rar_pkg::ST_DIV:   if (cnt_ff == 6'd63) state_in = rar_pkg::ST_FIN;
         rar_pkg::ST_FIN:   if (slot_free) state_in = rar_pkg::ST_IDLE;
         default:           state_in = rar_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = rar_pkg::MSEL_A;
      req_tready   = 1'b0;
      cnt_in       = cnt_ff;
      unique case (state_ff)
         rar_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         rar_pkg::ST_MUL_A: cmd.mul_en = 1'b1;
         rar_pkg::ST_MUL_B: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rar_pkg::MSEL_B;
         end
         rar_pkg::ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = rar_pkg::MSEL_D;
         end
         rar_pkg::ST_SUM:   cmd.sum_en = 1'b1;
         rar_pkg::ST_GCD: begin
            cmd.gcd_en    = !stat.num_zero;
            cmd.div_start = !stat.num_zero && stat.gcd_done;
            cnt_in        = '0;
         end
         rar_pkg::ST_DIV: begin
            cmd.div_en = 1'b1;
            cnt_in     = cnt_ff + 6'd1;
         end
         rar_pkg::ST_FIN:   cmd.out_load = slot_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rar_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/rar_checker.sv =====
// Port-level checks on the result channel, bound to the top level
`default_nettype none
`include "rational_arith_reduce_assert.svh"
module rar_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);
   logic rsp_known;
   logic rsp_err;
   logic rsp_ok;

   assign rsp_known = (rsp_tuser <= rar_pkg::STATUS_OVERFLOW);
   assign rsp_err   = rsp_tvalid && (rsp_tuser != rar_pkg::STATUS_OK);
   assign rsp_ok    = rsp_tvalid && (rsp_tuser == rar_pkg::STATUS_OK);

   `RAR_ASSERT_HOLD(a_rsp_hold, rsp_tvalid, rsp_tready, {rsp_tdata, rsp_tuser})
   `RAR_ASSERT(a_status_code, rsp_tvalid |-> rsp_known, "undefined status")
   `RAR_ASSERT(a_err_zero, rsp_err |-> (rsp_tdata == 64'd0), "error item not zero")
   `RAR_ASSERT(a_ok_den, rsp_ok |-> (rsp_tdata[62:32] != 31'd0), "ok item has zero denominator")
endmodule

bind rational_arith_reduce rar_checker u_rar_checker (.*);
`default_nettype wire
